// ===== rtl/wftt_pkg.sv =====
`default_nettype none
package wftt_pkg;

    localparam int unsigned DEF_ENTRIES      = 4096;
    localparam int unsigned DEF_MAX_WORD_LEN = 64;
    localparam int unsigned DEF_TOP_K        = 10;
    localparam int unsigned DEF_COUNT_WIDTH  = 32;

    localparam logic [1:0] CMD_TEXT   = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic KIND_SLOT = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_SRCH_LEN  = 15'b000000000000010,
        S_SRCH_LCHK = 15'b000000000000100,
        S_CMP_RD    = 15'b000000000001000,
        S_CMP_CHK   = 15'b000000000010000,
        S_ALLOC     = 15'b000000000100000,
        S_COPY_RD   = 15'b000000001000000,
        S_COPY_WR   = 15'b000000010000000,
        S_WDONE     = 15'b000000100000000,
        S_REP_RD    = 15'b000001000000000,
        S_REP_CHK   = 15'b000010000000000,
        S_REP_OUT   = 15'b000100000000000,
        S_RD_MEM    = 15'b001000000000000,
        S_RD_OUT    = 15'b010000000000000,
        S_SPARE     = 15'b100000000000000
    } t_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
            || (c == 8'h0C) || (c == 8'h0D);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/word_frequency_top_ten_unit.sv =====
`default_nettype none
// Word frequency counter with a top-ranked report.
// Request channel (i_valid / o_ready): command 0 feeds one text byte,
// command 1 ends the text and asks for a report, command 2 reads one byte
// of a stored word; command 3 is dropped. A request is taken only while
// the unit is idle.
// Result channel (o_valid / i_ready): a report gives TOP_K slots, rank 0
// first, last on the final one; a read gives one result with last set.
// A word end scans the stored entries one at a time, comparing bytes only
// for an entry of equal length, and copies a new word into the table
// when there is room. A report scans every allocated entry once per slot.
// Each table memory has a single read port.
// Reset clears the entry count and pending word; no clearing pass is
// needed since data of unallocated entries never reaches an output.
// A stalled receiver holds the result register; a unit with a new result
// waits in place until the pending result leaves, but idle takes requests.
module word_frequency_top_ten_unit #(
    parameter int unsigned ENTRIES      = wftt_pkg::DEF_ENTRIES,
    parameter int unsigned MAX_WORD_LEN = wftt_pkg::DEF_MAX_WORD_LEN,
    parameter int unsigned TOP_K        = wftt_pkg::DEF_TOP_K,
    parameter int unsigned COUNT_WIDTH  = wftt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic [11:0] i_entry_select,
    input  wire logic [5:0]  i_char_position,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [3:0]       o_rank,
    output logic [11:0]      o_entry_index,
    output logic [31:0]      o_frequency,
    output logic             o_found,
    output logic [6:0]       o_word_length,
    output logic [7:0]       o_byte_out,
    output logic             o_last
);
    import wftt_pkg::*;

    localparam int unsigned IDXW = $clog2(ENTRIES);
    localparam int unsigned CNTW = $clog2(ENTRIES + 1);
    localparam int unsigned LENW = $clog2(MAX_WORD_LEN + 1);
    localparam int unsigned POSW = $clog2(MAX_WORD_LEN);
    localparam int unsigned AW   = $clog2(ENTRIES * MAX_WORD_LEN);
    localparam int unsigned RKW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [7:0]             m_store [ENTRIES*MAX_WORD_LEN];
    logic [LENW-1:0]        m_len   [ENTRIES];
    logic [COUNT_WIDTH-1:0] m_freq  [ENTRIES];
    logic [7:0]             m_pend  [MAX_WORD_LEN];

    t_state                 r_state, n_state;
    logic [CNTW-1:0]        r_count, n_count;
    logic [LENW-1:0]        r_plen, n_plen;
    logic [CNTW-1:0]        r_i, n_i;
    logic [AW:0]            r_base, n_base;
    logic [LENW-1:0]        r_j, n_j;
    logic                   r_rep, n_rep;
    logic [RKW-1:0]         r_rank, n_rank;
    logic                   r_first, n_first;
    logic [COUNT_WIDTH-1:0] r_pc, n_pc;
    logic [IDXW-1:0]        r_px, n_px;
    logic [COUNT_WIDTH-1:0] r_best, n_best;
    logic [IDXW-1:0]        r_bi, n_bi;
    logic [11:0]            r_sel, n_sel;
    logic [5:0]             r_pos, n_pos;

    logic                   r_o_valid, n_o_valid;
    logic                   r_kind, n_kind;
    logic [3:0]             r_orank, n_orank;
    logic [11:0]            r_oidx, n_oidx;
    logic [31:0]            r_ofreq, n_ofreq;
    logic                   r_ofound, n_ofound;
    logic [6:0]             r_olen, n_olen;
    logic [7:0]             r_obyte, n_obyte;
    logic                   r_olast, n_olast;

    logic [7:0]             r_store_q, r_pend_q;
    logic [LENW-1:0]        r_len_q;
    logic [COUNT_WIDTH-1:0] r_freq_q;

    logic                   w_store_re, w_store_we;
    logic [AW-1:0]          w_store_ra, w_store_wa;
    logic                   w_len_re, w_len_we;
    logic [IDXW-1:0]        w_len_ra;
    logic                   w_freq_re, w_freq_we;
    logic [IDXW-1:0]        w_freq_ra, w_freq_wa;
    logic [COUNT_WIDTH-1:0] w_freq_wd;
    logic                   w_pend_re, w_pend_we;
    logic [POSW-1:0]        w_pend_ra;

    logic                   w_take, w_out_free, w_elig, w_sel_ok;
    logic [AW-1:0]          w_rd_addr;

    assign o_ready    = (r_state == S_IDLE);
    assign w_take     = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_sel_ok   = (32'(r_sel) < 32'(r_count));
    assign w_elig     = r_first || (r_freq_q < r_pc)
                        || ((r_freq_q == r_pc) && (r_i[IDXW-1:0] > r_px));
    assign w_rd_addr  = AW'(AW'(r_sel) * AW'(MAX_WORD_LEN))
                        + ((32'(r_pos) < MAX_WORD_LEN) ? AW'(r_pos) : AW'(0));

    always_ff @(posedge i_clk) begin
        if (w_store_we) m_store[w_store_wa] <= r_pend_q;
        if (w_store_re) r_store_q <= m_store[w_store_ra];
        if (w_len_we) m_len[r_count[IDXW-1:0]] <= r_plen;
        if (w_len_re) r_len_q <= m_len[w_len_ra];
        if (w_freq_we) m_freq[w_freq_wa] <= w_freq_wd;
        if (w_freq_re) r_freq_q <= m_freq[w_freq_ra];
        if (w_pend_we) m_pend[r_plen[POSW-1:0]] <= i_text_byte;
        if (w_pend_re) r_pend_q <= m_pend[w_pend_ra];
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_plen = r_plen; n_i = r_i;
        n_base = r_base; n_j = r_j; n_rep = r_rep; n_rank = r_rank;
        n_first = r_first; n_pc = r_pc; n_px = r_px; n_best = r_best;
        n_bi = r_bi; n_sel = r_sel; n_pos = r_pos;
        n_o_valid = r_o_valid && !i_ready;
        n_kind = r_kind; n_orank = r_orank; n_oidx = r_oidx; n_ofreq = r_ofreq;
        n_ofound = r_ofound; n_olen = r_olen; n_obyte = r_obyte; n_olast = r_olast;
        w_store_re = 1'b0; w_store_we = 1'b0;
        w_store_ra = r_base[AW-1:0] + AW'(r_j);
        w_store_wa = r_base[AW-1:0] + AW'(r_j);
        w_len_re = 1'b0; w_len_we = 1'b0; w_len_ra = r_i[IDXW-1:0];
        w_freq_re = 1'b0; w_freq_we = 1'b0;
        w_freq_ra = r_i[IDXW-1:0]; w_freq_wa = r_i[IDXW-1:0];
        w_freq_wd = (r_freq_q == CMAX) ? r_freq_q : r_freq_q + COUNT_WIDTH'(1);
        w_pend_re = 1'b0; w_pend_we = 1'b0; w_pend_ra = r_j[POSW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_i = '0; n_base = '0; n_best = '0; n_bi = '0;
                    n_rank = '0; n_first = 1'b1;
                    n_sel = i_entry_select; n_pos = i_char_position;
                    unique case (i_command)
                        CMD_TEXT: begin
                            if (is_space(i_text_byte)) begin
                                n_rep = 1'b0;
                                if (r_plen != '0) n_state = S_SRCH_LEN;
                            end else if (32'(r_plen) < MAX_WORD_LEN) begin
                                w_pend_we = 1'b1;
                                n_plen = r_plen + LENW'(1);
                            end
                        end
                        CMD_REPORT: begin
                            n_rep = 1'b1;
                            n_state = (r_plen != '0) ? S_SRCH_LEN : S_REP_RD;
                        end
                        CMD_READ: n_state = S_RD_MEM;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH_LEN: begin
                if (r_i == r_count) begin
                    n_state = S_ALLOC;
                end else begin
                    w_len_re = 1'b1; w_freq_re = 1'b1;
                    n_state = S_SRCH_LCHK;
                end
            end
            S_SRCH_LCHK: begin
                n_j = '0;
                if (r_len_q == r_plen) begin
                    n_state = S_CMP_RD;
                end else begin
                    n_i = r_i + CNTW'(1);
                    n_base = r_base + (AW+1)'(MAX_WORD_LEN);
                    n_state = S_SRCH_LEN;
                end
            end
            S_CMP_RD: begin
                if (r_j == r_plen) begin
                    w_freq_we = 1'b1;
                    n_state = S_WDONE;
                end else begin
                    w_store_re = 1'b1; w_pend_re = 1'b1;
                    n_state = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (r_store_q == r_pend_q) begin
                    n_j = r_j + LENW'(1);
                    n_state = S_CMP_RD;
                end else begin
                    n_i = r_i + CNTW'(1);
                    n_base = r_base + (AW+1)'(MAX_WORD_LEN);
                    n_state = S_SRCH_LEN;
                end
            end
            S_ALLOC: begin
                n_j = '0;
                n_state = (32'(r_count) == ENTRIES) ? S_WDONE : S_COPY_RD;
            end
            S_COPY_RD: begin
                if (r_j == r_plen) begin
                    w_len_we = 1'b1; w_freq_we = 1'b1;
                    w_freq_wa = r_count[IDXW-1:0];
                    w_freq_wd = COUNT_WIDTH'(1);
                    n_count = r_count + CNTW'(1);
                    n_state = S_WDONE;
                end else begin
                    w_pend_re = 1'b1;
                    n_state = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                w_store_we = 1'b1;
                n_j = r_j + LENW'(1);
                n_state = S_COPY_RD;
            end
            S_WDONE: begin
                n_plen = '0; n_i = '0; n_best = '0; n_bi = '0;
                n_state = r_rep ? S_REP_RD : S_IDLE;
            end
            S_REP_RD: begin
                if (r_i == r_count) begin
                    w_len_re = 1'b1; w_len_ra = r_bi;
                    n_state = S_REP_OUT;
                end else begin
                    w_freq_re = 1'b1;
                    n_state = S_REP_CHK;
                end
            end
            S_REP_CHK: begin
                if (w_elig && (r_freq_q > r_best)) begin
                    n_best = r_freq_q; n_bi = r_i[IDXW-1:0];
                end
                n_i = r_i + CNTW'(1);
                n_state = S_REP_RD;
            end
            S_REP_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1; n_kind = KIND_SLOT;
                    n_orank = 4'(r_rank);
                    n_ofound = (r_best != '0);
                    n_oidx = (r_best != '0) ? 12'(r_bi) : 12'd0;
                    n_ofreq = 32'(r_best);
                    n_olen = (r_best != '0) ? 7'(r_len_q) : 7'd0;
                    n_obyte = 8'd0;
                    n_olast = (32'(r_rank) == TOP_K - 1);
                    n_pc = r_best; n_px = r_bi; n_first = 1'b0;
                    n_i = '0; n_best = '0; n_bi = '0;
                    n_rank = r_rank + RKW'(1);
                    n_state = (32'(r_rank) == TOP_K - 1) ? S_IDLE : S_REP_RD;
                end
            end
            S_RD_MEM: begin
                w_len_re = 1'b1; w_len_ra = IDXW'(r_sel);
                w_store_re = 1'b1; w_store_ra = w_rd_addr;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1; n_kind = KIND_BYTE;
                    n_orank = 4'd0; n_oidx = r_sel; n_ofreq = 32'd0;
                    n_ofound = w_sel_ok;
                    n_olen = w_sel_ok ? 7'(r_len_q) : 7'd0;
                    n_obyte = (w_sel_ok && (32'(r_pos) < 32'(r_len_q))) ? r_store_q : 8'd0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_plen <= '0;
            r_rep <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_plen <= n_plen;
            r_rep <= n_rep;
            r_o_valid <= n_o_valid;
        end
        r_i <= n_i; r_base <= n_base; r_j <= n_j; r_rank <= n_rank;
        r_first <= n_first; r_pc <= n_pc; r_px <= n_px; r_best <= n_best;
        r_bi <= n_bi; r_sel <= n_sel; r_pos <= n_pos;
        r_kind <= n_kind; r_orank <= n_orank; r_oidx <= n_oidx; r_ofreq <= n_ofreq;
        r_ofound <= n_ofound; r_olen <= n_olen; r_obyte <= n_obyte; r_olast <= n_olast;
    end

    assign o_valid       = r_o_valid;
    assign o_result_kind = r_kind;
    assign o_rank        = r_orank;
    assign o_entry_index = r_oidx;
    assign o_frequency   = r_ofreq;
    assign o_found       = r_ofound;
    assign o_word_length = r_olen;
    assign o_byte_out    = r_obyte;
    assign o_last        = r_olast;

endmodule
`default_nettype wire

// ===== rtl/wftt_checker.sv =====
`default_nettype none
module wftt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_result_kind,
    input wire logic [31:0] o_frequency,
    input wire logic        o_found,
    input wire logic [7:0]  o_byte_out,
    input wire logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind |-> o_last)
        else $error("read result without last");
    a_slot_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_kind |-> o_byte_out == 8'd0)
        else $error("report slot carries a byte");
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_kind && !o_found |-> o_frequency == 32'd0)
        else $error("empty slot with a count");
endmodule

bind word_frequency_top_ten_unit wftt_checker u_wftt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_result_kind(o_result_kind), .o_frequency(o_frequency), .o_found(o_found),
    .o_byte_out(o_byte_out), .o_last(o_last)
);
`default_nettype wire
